// ----- sv/lsg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsg_pkg
// Shared constants, types and the reciprocal table of the Legendre series
// generator.
// ----------------------------------------------------------------------------
package lsg_pkg;

   localparam int MAX_DEGREE = 16;
   localparam int FRAC_BITS  = 14;

   localparam int VAL_W = 16;
   localparam int DEG_W = 5;
   localparam int VAL_MAX = 32767;

   // width of a polynomial order k
   localparam int KW = $clog2(MAX_DEGREE + 1);
   // width of the rounded dividend (numerator scaled down by 2^FRAC_BITS)
   localparam int DW = 16 + $clog2(3 * MAX_DEGREE);
   // reciprocal shift chosen so that floor(d / k) is exact for every d < 2^DW
   localparam int RECIP_SHIFT = DW + KW;
   localparam int RECIP_W     = RECIP_SHIFT;
   localparam int QP_W        = DW + RECIP_W;

   localparam int PA_W   = 2 * VAL_W + KW + 2;
   localparam int PB_W   = VAL_W + KW + 2 + FRAC_BITS;
   localparam int WIDE_W = ((PA_W > PB_W) ? PA_W : PB_W) + 1;

   // width used for the range check against 1.0
   localparam int XR_W = FRAC_BITS + 18;

   // 1.0 clamped to the value range
   localparam logic signed [VAL_W-1:0] ONE_SAT =
      (FRAC_BITS >= VAL_W - 1) ? VAL_W'(VAL_MAX) : VAL_W'(1 << FRAC_BITS);

   typedef logic [MAX_DEGREE:0][RECIP_W-1:0] recip_tab_type;

   // ceil(2^RECIP_SHIFT / k) per order, by shift-subtract at elaboration
   function automatic recip_tab_type build_recip();
      recip_tab_type tab;
      longint num;
      longint rem;
      longint quo;
      int k;
      int i;
      tab = '0;
      for (k = 2; k <= MAX_DEGREE; k++) begin
         num = (longint'(1) <<< RECIP_SHIFT) + longint'(k - 1);
         rem = 0;
         quo = 0;
         for (i = RECIP_SHIFT; i >= 0; i--) begin
            rem = (rem <<< 1) | ((num >>> i) & longint'(1));
            quo = quo <<< 1;
            if (rem >= longint'(k)) begin
               rem = rem - longint'(k);
               quo = quo | longint'(1);
            end
         end
         tab[k] = RECIP_W'(quo);
      end
      return tab;
   endfunction

   localparam recip_tab_type RECIP = build_recip();

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_ONE,
      SEL_X,
      SEL_REC
   } emit_sel_type;

   typedef struct packed {
      logic         load;
      logic         mul_x;
      logic         mul_c;
      logic         round;
      logic         scale;
      logic         emit;
      emit_sel_type emit_sel;
      logic [KW-1:0] order;
   } dp_cmd_type;

   typedef struct packed {
      logic range_bad;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- sv/lsg_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsg_datapath
// Sample and history registers, recurrence arithmetic, rounding, reciprocal
// divide and saturation of each polynomial value.
// ----------------------------------------------------------------------------
module lsg_datapath (
   input  wire logic                           clock,
   input  wire lsg_pkg::dp_cmd_type            cmd,
   input  wire logic signed [lsg_pkg::VAL_W-1:0] req_sample,
   output lsg_pkg::dp_status_type              status,
   output logic signed [lsg_pkg::VAL_W-1:0]    rsp_value
);

   logic signed [lsg_pkg::VAL_W-1:0]    x_ff;
   logic signed [lsg_pkg::VAL_W-1:0]    p1_ff;
   logic signed [lsg_pkg::VAL_W-1:0]    p2_ff;
   logic signed [2*lsg_pkg::VAL_W-1:0]  xp_ff;
   logic signed [lsg_pkg::WIDE_W-1:0]   a_ff;
   logic signed [lsg_pkg::WIDE_W-1:0]   b_ff;
   logic [lsg_pkg::DW-1:0]              d_ff;
   logic                                neg_ff;
   logic [lsg_pkg::QP_W-1:0]            qp_ff;
   logic signed [lsg_pkg::VAL_W-1:0]    val_ff;

   logic signed [lsg_pkg::XR_W-1:0]     x_wide;
   logic signed [lsg_pkg::XR_W-1:0]     one_wide;
   logic [lsg_pkg::KW:0]                c1;
   logic signed [lsg_pkg::KW+1:0]       c1_s;
   logic signed [lsg_pkg::KW:0]         c2_s;
   logic signed [lsg_pkg::WIDE_W-1:0]   prod_a;
   logic signed [lsg_pkg::WIDE_W-1:0]   prod_b;
   logic signed [lsg_pkg::WIDE_W-1:0]   num;
   logic [lsg_pkg::WIDE_W-1:0]          mag;
   logic [lsg_pkg::WIDE_W-1:0]          half;
   logic [lsg_pkg::WIDE_W-1:0]          rsum;
   logic [lsg_pkg::RECIP_W-1:0]         recip;
   logic [lsg_pkg::DW-1:0]              quo;
   logic [lsg_pkg::DW-1:0]              quo_neg;
   logic signed [lsg_pkg::VAL_W-1:0]    rec_val;
   logic signed [lsg_pkg::VAL_W-1:0]    val_in;

   assign x_wide    = lsg_pkg::XR_W'(x_ff);
   assign one_wide  = lsg_pkg::XR_W'(1) <<< lsg_pkg::FRAC_BITS;
   assign status.range_bad = (x_wide > one_wide) || (x_wide < -one_wide);

   // coefficients 2k-1 and k-1
   assign c1     = {cmd.order, 1'b0} - (lsg_pkg::KW+1)'(1);
   assign c1_s   = {1'b0, c1};
   assign c2_s   = {1'b0, cmd.order - lsg_pkg::KW'(1)};
   assign prod_a = xp_ff * c1_s;
   assign prod_b = p2_ff * c2_s;

   // round half away from zero on the magnitude, then drop the fraction
   assign num  = a_ff - b_ff;
   assign mag  = num[lsg_pkg::WIDE_W-1] ? $unsigned(-num) : $unsigned(num);
   assign half = lsg_pkg::WIDE_W'(cmd.order) << (lsg_pkg::FRAC_BITS - 1);
   assign rsum = mag + half;

   assign recip   = lsg_pkg::RECIP[cmd.order];
   assign quo     = qp_ff[lsg_pkg::RECIP_SHIFT +: lsg_pkg::DW];
   assign quo_neg = -quo;

   always_comb begin
      if (neg_ff) begin
         if (quo > lsg_pkg::DW'(lsg_pkg::VAL_MAX + 1)) begin
            rec_val = {1'b1, {(lsg_pkg::VAL_W-1){1'b0}}};
         end else begin
            rec_val = quo_neg[lsg_pkg::VAL_W-1:0];
         end
      end else begin
         if (quo > lsg_pkg::DW'(lsg_pkg::VAL_MAX)) begin
            rec_val = lsg_pkg::VAL_W'(lsg_pkg::VAL_MAX);
         end else begin
            rec_val = quo[lsg_pkg::VAL_W-1:0];
         end
      end
   end

   always_comb begin
      case (cmd.emit_sel)
         lsg_pkg::SEL_ZERO: val_in = '0;
         lsg_pkg::SEL_ONE:  val_in = lsg_pkg::ONE_SAT;
         lsg_pkg::SEL_X:    val_in = x_ff;
         lsg_pkg::SEL_REC:  val_in = rec_val;
         default:           val_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= req_sample;
      end
      if (cmd.mul_x) begin
         xp_ff <= x_ff * p1_ff;
      end
      if (cmd.mul_c) begin
         a_ff <= prod_a;
         b_ff <= prod_b <<< lsg_pkg::FRAC_BITS;
      end
      if (cmd.round) begin
         d_ff   <= rsum[lsg_pkg::FRAC_BITS +: lsg_pkg::DW];
         neg_ff <= num[lsg_pkg::WIDE_W-1];
      end
      if (cmd.scale) begin
         qp_ff <= lsg_pkg::QP_W'(d_ff) * lsg_pkg::QP_W'(recip);
      end
      if (cmd.emit) begin
         val_ff <= val_in;
         // emitted value becomes the newest history entry
         p2_ff  <= p1_ff;
         p1_ff  <= val_in;
      end
   end

   assign rsp_value = val_ff;

endmodule
`default_nettype wire

// ----- sv/lsg_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsg_ctrl
// Sequencer for one sample: range check, P0 and P1, then states MUL_X to EMIT
// per recurrence step; holds the degree register and the result strobe.
// ----------------------------------------------------------------------------
module lsg_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         csr_wr_en,
   input  wire logic [lsg_pkg::DEG_W-1:0]    csr_wr_data,
   input  wire lsg_pkg::dp_status_type       status,
   output lsg_pkg::dp_cmd_type               cmd,
   output logic                              rsp_strobe,
   output logic [lsg_pkg::DEG_W-1:0]         rsp_order,
   output logic                              rsp_last,
   output logic                              rsp_range_error
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FIRST,
      ST_MUL_X,
      ST_MUL_C,
      ST_ROUND,
      ST_SCALE,
      ST_EMIT
   } state_type;

   state_type                   state_ff;
   logic [lsg_pkg::DEG_W-1:0]   degree_ff;
   logic [lsg_pkg::KW-1:0]      n_ff;
   logic [lsg_pkg::KW-1:0]      k_ff;
   logic                        strobe_ff;
   logic [lsg_pkg::DEG_W-1:0]   order_ff;
   logic                        last_ff;
   logic                        err_ff;
   logic [lsg_pkg::KW-1:0]      n_in;

   assign n_in = (int'(degree_ff) > lsg_pkg::MAX_DEGREE) ?
                 lsg_pkg::KW'(lsg_pkg::MAX_DEGREE) : lsg_pkg::KW'(degree_ff);

   always_comb begin
      cmd          = '0;
      cmd.emit_sel = lsg_pkg::SEL_ZERO;
      cmd.order    = k_ff;
      case (state_ff)
         ST_IDLE:  cmd.load = start;
         ST_CHECK: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = status.range_bad ? lsg_pkg::SEL_ZERO : lsg_pkg::SEL_ONE;
         end
         ST_FIRST: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = lsg_pkg::SEL_X;
         end
         ST_MUL_X: cmd.mul_x = 1'b1;
         ST_MUL_C: cmd.mul_c = 1'b1;
         ST_ROUND: cmd.round = 1'b1;
         ST_SCALE: cmd.scale = 1'b1;
         ST_EMIT: begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = lsg_pkg::SEL_REC;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         degree_ff <= lsg_pkg::DEG_W'(2);
         n_ff      <= '0;
         k_ff      <= '0;
         strobe_ff <= 1'b0;
         order_ff  <= '0;
         last_ff   <= 1'b0;
         err_ff    <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
         err_ff    <= 1'b0;
         if (csr_wr_en) begin
            degree_ff <= csr_wr_data;
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  n_ff     <= n_in;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               strobe_ff <= 1'b1;
               order_ff  <= '0;
               if (status.range_bad) begin
                  err_ff   <= 1'b1;
                  last_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  last_ff  <= (n_ff == '0);
                  state_ff <= (n_ff == '0) ? ST_IDLE : ST_FIRST;
               end
            end
            ST_FIRST: begin
               strobe_ff <= 1'b1;
               order_ff  <= lsg_pkg::DEG_W'(1);
               last_ff   <= (n_ff == lsg_pkg::KW'(1));
               k_ff      <= lsg_pkg::KW'(2);
               state_ff  <= (n_ff == lsg_pkg::KW'(1)) ? ST_IDLE : ST_MUL_X;
            end
            ST_MUL_X: state_ff <= ST_MUL_C;
            ST_MUL_C: state_ff <= ST_ROUND;
            ST_ROUND: state_ff <= ST_SCALE;
            ST_SCALE: state_ff <= ST_EMIT;
            ST_EMIT: begin
               strobe_ff <= 1'b1;
               order_ff  <= lsg_pkg::DEG_W'(k_ff);
               last_ff   <= (k_ff == n_ff);
               if (k_ff == n_ff) begin
                  state_ff <= ST_IDLE;
               end else begin
                  k_ff     <= k_ff + lsg_pkg::KW'(1);
                  state_ff <= ST_MUL_X;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_order       = order_ff;
   assign rsp_last        = last_ff;
   assign rsp_range_error = err_ff;

   // the final result of a sample always lands as the sequencer goes idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && last_ff |-> state_ff == ST_IDLE)
      else $error("last result while sequencer still running");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> strobe_ff && last_ff && order_ff == '0)
      else $error("range error not a single order-zero transaction");

   a_start_check: assert property (@(posedge clock) disable iff (reset)
      start && state_ff == ST_IDLE |=> state_ff == ST_CHECK)
      else $error("accepted sample did not enter range check");

   a_order_bound: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> int'(order_ff) <= int'(n_ff))
      else $error("result order beyond clamped degree");

endmodule
`default_nettype wire

// ----- sv/legendre_series_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// legendre_series_generator
// Emits P0(x) .. Pn(x) of a Q1.14 sample by the three-term recurrence.
// ----------------------------------------------------------------------------
// A sample is taken when start is high while busy is low; n is the degree
// register clamped to 16. The block then emits P0 from the range check and
// P1 after it, followed by one value per recurrence step (history multiply,
// coefficient multiply, rounding, reciprocal multiply, saturation). Busy
// stays high until the last result of a sample is registered. At degree
// zero, or when |x| exceeds 1.0 (one result with range_error set and value
// zero), a sample yields a single result. Each result is on the rsp_ ports
// for exactly one cycle with rsp_strobe high; the receiver cannot hold
// results off and must take every transaction.
// Write the degree register only while busy is low and no result is due.
// ----------------------------------------------------------------------------
module legendre_series_generator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic signed [lsg_pkg::VAL_W-1:0]   req_sample,
   output logic                                    rsp_strobe,
   output logic [lsg_pkg::DEG_W-1:0]               rsp_order,
   output logic signed [lsg_pkg::VAL_W-1:0]        rsp_value,
   output logic                                    rsp_last,
   output logic                                    rsp_range_error,
   input  wire logic                               csr_wr_en,
   input  wire logic [lsg_pkg::DEG_W-1:0]          csr_wr_data
);

   lsg_pkg::dp_cmd_type    cmd;
   lsg_pkg::dp_status_type status;

   lsg_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .status          (status),
      .cmd             (cmd),
      .rsp_strobe      (rsp_strobe),
      .rsp_order       (rsp_order),
      .rsp_last        (rsp_last),
      .rsp_range_error (rsp_range_error)
   );

   lsg_datapath u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .req_sample (req_sample),
      .status     (status),
      .rsp_value  (rsp_value)
   );

endmodule
`default_nettype wire

// ----- verif/legendre_series_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// legendre_series_checker
// Watches the sample, result and degree ports of the Legendre series
// generator, predicts P0..Pn for every accepted sample and compares each
// result transaction against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module legendre_series_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic signed [lsg_pkg::VAL_W-1:0]  req_sample,
   input  logic                              rsp_strobe,
   input  logic [lsg_pkg::DEG_W-1:0]         rsp_order,
   input  logic signed [lsg_pkg::VAL_W-1:0]  rsp_value,
   input  logic                              rsp_last,
   input  logic                              rsp_range_error,
   input  logic                              csr_wr_en,
   input  logic [lsg_pkg::DEG_W-1:0]         csr_wr_data,
   output int                                failures,
   output int                                pending,
   output int                                terms_checked,
   output int                                range_errors
);

   typedef struct packed {
      logic [lsg_pkg::DEG_W-1:0]        order;
      logic signed [lsg_pkg::VAL_W-1:0] value;
      logic                             last;
      logic                             range_error;
   } poly_term_type;

   poly_term_type expected_terms[$];
   logic [lsg_pkg::DEG_W-1:0] degree_shadow = 5'd2;
   int fail_count    = 0;
   int checked_count = 0;
   int range_count   = 0;

   function automatic longint clamp16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // nearest step, halves away from zero; den is always positive here
   function automatic longint round_div(input longint num, input longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic void push_term(input int k, input longint v, input bit last,
                                     input bit err);
      poly_term_type t;
      t.order       = lsg_pkg::DEG_W'(k);
      t.value       = lsg_pkg::VAL_W'(v);
      t.last        = last;
      t.range_error = err;
      expected_terms.insert(expected_terms.size(), t);
   endfunction

   function automatic void predict_terms(input logic signed [lsg_pkg::VAL_W-1:0] x,
                                         input logic [lsg_pkg::DEG_W-1:0] deg);
      longint unit;
      longint xv;
      longint prev2;
      longint prev1;
      longint num;
      longint v;
      int n;
      int k;
      unit = longint'(1) <<< lsg_pkg::FRAC_BITS;
      xv = longint'(x);
      n = (int'(deg) > lsg_pkg::MAX_DEGREE) ? lsg_pkg::MAX_DEGREE : int'(deg);
      if (xv > unit || xv < -unit) begin
         push_term(0, 0, 1'b1, 1'b1);
         return;
      end
      prev2 = clamp16(unit);
      push_term(0, prev2, n == 0, 1'b0);
      if (n == 0) return;
      prev1 = clamp16(xv);
      push_term(1, prev1, n == 1, 1'b0);
      for (k = 2; k <= n; k++) begin
         num = longint'(2 * k - 1) * xv * prev1 - longint'(k - 1) * prev2 * unit;
         v = clamp16(round_div(num, longint'(k) * unit));
         push_term(k, v, k == n, 1'b0);
         prev2 = prev1;
         prev1 = v;
      end
   endfunction

   always @(posedge clock) begin : watch
      poly_term_type want;
      if (reset) begin
         expected_terms.delete();
         degree_shadow = 5'd2;
      end else begin
         // results first: a new sample at this edge cannot have produced one yet
         if (rsp_strobe) begin
            checked_count++;
            if (rsp_range_error) range_count++;
            if (expected_terms.size() == 0) begin
               $error("unexpected result transaction: order %0d value %0d",
                      rsp_order, rsp_value);
               fail_count++;
            end else begin
               want = expected_terms.pop_front();
               if (rsp_order !== want.order) begin
                  $error("order: expected %0d, actual %0d", want.order, rsp_order);
                  fail_count++;
               end
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d, actual %0d", want.value, rsp_value);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_last);
                  fail_count++;
               end
               if (rsp_range_error !== want.range_error) begin
                  $error("range_error: expected %0d, actual %0d",
                         want.range_error, rsp_range_error);
                  fail_count++;
               end
            end
         end
         if (start && !busy) predict_terms(req_sample, degree_shadow);
         if (csr_wr_en) degree_shadow = csr_wr_data;
      end
      failures      <= fail_count;
      pending       <= expected_terms.size();
      terms_checked <= checked_count;
      range_errors  <= range_count;
   end

endmodule

// ----- verif/legendre_series_generator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// legendre_series_generator_test
// Drives samples and degree settings into the Legendre series generator:
// a directed pass over the extremes, then random samples under several
// sender idle patterns. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module legendre_series_generator_test;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             start       = 1'b0;
   logic signed [lsg_pkg::VAL_W-1:0] req_sample  = '0;
   logic                             csr_wr_en   = 1'b0;
   logic [lsg_pkg::DEG_W-1:0]        csr_wr_data = '0;

   logic                             busy;
   logic                             rsp_strobe;
   logic [lsg_pkg::DEG_W-1:0]        rsp_order;
   logic signed [lsg_pkg::VAL_W-1:0] rsp_value;
   logic                             rsp_last;
   logic                             rsp_range_error;

   int failures;
   int pending;
   int terms_checked;
   int range_errors;

   int  idle_pct      = 0;
   int  samples_sent  = 0;
   int  degree_writes = 0;
   int  drains        = 0;
   bit  leftover      = 1'b0;

   always #6 clock = ~clock;

   legendre_series_generator i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_sample      (req_sample),
      .rsp_strobe      (rsp_strobe),
      .rsp_order       (rsp_order),
      .rsp_value       (rsp_value),
      .rsp_last        (rsp_last),
      .rsp_range_error (rsp_range_error),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   legendre_series_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_sample      (req_sample),
      .rsp_strobe      (rsp_strobe),
      .rsp_order       (rsp_order),
      .rsp_value       (rsp_value),
      .rsp_last        (rsp_last),
      .rsp_range_error (rsp_range_error),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .failures        (failures),
      .pending         (pending),
      .terms_checked   (terms_checked),
      .range_errors    (range_errors)
   );

   // entered and left at a falling edge; start stays high after the transaction
   task automatic send_sample(input logic signed [lsg_pkg::VAL_W-1:0] x);
      bit taken;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start      <= 1'b1;
      req_sample <= x;
      do begin
         @(posedge clock);
         taken = !busy;
         @(negedge clock);
      end while (!taken);
      samples_sent++;
   endtask

   // hold off until every predicted result has come back and the block is idle, or the wait limit is reached
   task automatic drain(input int limit);
      int waited;
      waited = 0;
      start <= 1'b0;
      @(negedge clock);
      while ((pending != 0 || busy) && waited < limit) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);
      drains++;
   endtask

   task automatic set_degree(input logic [lsg_pkg::DEG_W-1:0] d);
      drain(20000);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= d;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      degree_writes++;
   endtask

   function automatic logic signed [lsg_pkg::VAL_W-1:0] pick_sample();
      int r;
      r = $urandom_range(99);
      if (r < 80) return lsg_pkg::VAL_W'($urandom_range(32768) - 16384);
      if (r < 90) begin
         case ($urandom_range(5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd16383;
            3: return -16'sd16385;
            4: return 16'sd16385;
            default: return 16'sd0;
         endcase
      end
      return lsg_pkg::VAL_W'($urandom_range(65535));
   endfunction

   function automatic logic [lsg_pkg::DEG_W-1:0] pick_degree();
      int r;
      r = $urandom_range(99);
      if (r < 10) return lsg_pkg::DEG_W'($urandom_range(31, 17));
      if (r < 25) return lsg_pkg::DEG_W'(lsg_pkg::MAX_DEGREE);
      return lsg_pkg::DEG_W'($urandom_range(15));
   endfunction

   initial begin : stimulus
      int phase;
      int chunk;
      int i;
      int idle_plan [4] = '{0, 88, 0, 27};
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset degree is two
      send_sample(16'sd16384);
      send_sample(-16'sd8192);

      set_degree(5'd16);
      send_sample(16'sd16384);
      send_sample(-16'sd16384);
      send_sample(16'sd0);
      send_sample(16'sd1);
      send_sample(-16'sd1);
      send_sample(16'sd11585);
      send_sample(-16'sd11585);
      send_sample(16'sd8193);
      send_sample(16'sd16383);
      send_sample(-16'sd16383);
      // just outside the unit interval, and the full-scale codes
      send_sample(16'sd16385);
      send_sample(-16'sd16385);
      send_sample(16'sd32767);
      send_sample(-16'sd32768);

      set_degree(5'd0);
      send_sample(16'sd0);
      send_sample(-16'sd16384);
      send_sample(16'sd20000);

      set_degree(5'd1);
      send_sample(16'sd5000);
      send_sample(-16'sd16384);

      // degrees past the table top clamp to the maximum
      set_degree(5'd31);
      send_sample(16'sd12345);
      send_sample(-16'sd3);
      set_degree(5'd17);
      send_sample(16'sd7777);

      for (phase = 0; phase < 4; phase++) begin
         idle_pct = idle_plan[phase];
         for (chunk = 0; chunk < 4; chunk++) begin
            set_degree(pick_degree());
            for (i = 0; i < 25; i++) begin
               if ($urandom_range(99) < 3) drain(20000);
               send_sample(pick_sample());
            end
         end
      end

      drain(20000);
      repeat (10) @(negedge clock);
      if (pending != 0) begin
         $error("%0d expected result transactions never arrived", pending);
         leftover = 1'b1;
      end
      $display("covered %0d samples over %0d degree settings, %0d pauses to idle",
               samples_sent, degree_writes, drains);
      $display("checked %0d result transactions, %0d of them out-of-range flags",
               terms_checked, range_errors);
      if (failures == 0 && !leftover) begin
         $display("legendre_series_generator test passed");
      end else begin
         $display("legendre_series_generator test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #5ms;
      $display("legendre_series_generator test failed");
      $finish;
   end

endmodule
